### design/owbm_pkg.sv
package owbm_pkg;

    // default counter width for the slot timers
    localparam int COUNT_WIDTH_DEF = 10;

    // widths of the configuration port
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int NUM_REGS    = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRES_SAMPLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WR1_LOW     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WR0_LOW     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WR_SLOT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RD_LOW      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RD_SAMPLE   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RD_SLOT     = 3'd7;

    localparam logic [CFG_DATA_W-1:0] REG_RESET_VAL [NUM_REGS] =
        '{10'd640, 10'd62, 10'd5, 10'd90, 10'd95, 10'd2, 10'd10, 10'd90};
    localparam logic [CFG_DATA_W-1:0] REG_MIN_VAL [NUM_REGS] =
        '{10'd1, 10'd1, 10'd1, 10'd1, 10'd2, 10'd1, 10'd2, 10'd3};

    // request opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // classified request
    typedef struct packed {
        logic       start_reset;
        logic       start_write;
        logic       start_read;
        logic [7:0] tx_byte;
        logic       bus_level;
    } t_cmd;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_stat;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       presence;
        logic       done_res;
        logic       busy_res;
        logic       bus_drive_low;
    } t_res;

endpackage

### design/owbm_front.sv
module owbm_front (
    input  logic [1:0]    i_op,
    input  logic [7:0]    i_tx_byte,
    input  logic          i_bus_level,
    output owbm_pkg::t_cmd o_cmd
);

    // decode opcode into start flags, at most one set; tx byte only kept for writes
    always_comb begin
        o_cmd.start_reset = 1'b0;
        o_cmd.start_write = 1'b0;
        o_cmd.start_read  = 1'b0;
        o_cmd.tx_byte     = 8'd0;
        o_cmd.bus_level   = i_bus_level;
        case (i_op)
            owbm_pkg::OP_TICK: begin
            end
            owbm_pkg::OP_RESET: begin
                o_cmd.start_reset = 1'b1;
            end
            owbm_pkg::OP_WRITE: begin
                o_cmd.start_write = 1'b1;
                o_cmd.tx_byte     = i_tx_byte;
            end
            owbm_pkg::OP_READ: begin
                o_cmd.start_read = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

### design/owbm_fifo.sv
module owbm_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  owbm_pkg::t_cmd       i_data,
    input  logic                 i_pop,
    output owbm_pkg::t_cmd       o_data,
    output owbm_pkg::t_fifo_stat o_stat
);

    owbm_pkg::t_cmd r_mem [owbm_pkg::FIFO_DEPTH];

    logic [owbm_pkg::FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [owbm_pkg::FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [owbm_pkg::FIFO_CNT_W-1:0] r_count, n_count;
    logic                            w_push, w_pop;

    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == owbm_pkg::FIFO_CNT_W'(owbm_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);

    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    assign o_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### design/owbm_back.sv
module owbm_back #(
    parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_cmd_valid,
    input  owbm_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output owbm_pkg::t_res                      o_res
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_RLOW  = 3'd1;
    localparam logic [2:0] PH_RREL  = 3'd2;
    localparam logic [2:0] PH_RHIGH = 3'd3;
    localparam logic [2:0] PH_WRITE = 3'd4;
    localparam logic [2:0] PH_READ  = 3'd5;

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // timing registers, held already clamped to their minimum
    logic [COUNT_WIDTH-1:0] r_eff [owbm_pkg::NUM_REGS];
    logic [COUNT_WIDTH-1:0] w_cfg_val, w_cfg_min;

    logic [2:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [2:0]             r_bit, n_bit;
    logic [7:0]             r_shift, n_shift;
    logic                   r_pres, n_pres;
    logic [7:0]             r_rx, n_rx;
    logic                   r_out_valid;
    owbm_pkg::t_res         r_out, n_out;

    logic [2:0]             v_ph;
    logic [COUNT_WIDTH-1:0] v_tick, v_inc, v_low, v_sp;
    logic [7:0]             v_shift;
    logic [2:0]             v_bit;
    logic                   v_drive, v_done, v_finish;

    assign w_cfg_val = COUNT_WIDTH'(i_cfg_data);
    assign w_cfg_min = COUNT_WIDTH'(owbm_pkg::REG_MIN_VAL[i_cfg_index]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
                r_eff[i] <= COUNT_WIDTH'(owbm_pkg::REG_RESET_VAL[i]);
            end
        end else if (i_cfg_we) begin
            r_eff[i_cfg_index] <= (w_cfg_val < w_cfg_min) ? w_cfg_min : w_cfg_val;
        end
    end

    // take the next tick whenever the output register is free or draining
    assign o_pop       = i_cmd_valid && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // read sample point: pulled onto the last slot tick if beyond the slot
    assign v_sp = (r_eff[owbm_pkg::REG_RD_SAMPLE] < r_eff[owbm_pkg::REG_RD_SLOT]) ?
                  r_eff[owbm_pkg::REG_RD_SAMPLE] :
                  r_eff[owbm_pkg::REG_RD_SLOT] - CNT_ONE;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_pres   = r_pres;
        n_rx     = r_rx;
        v_drive  = 1'b0;
        v_done   = 1'b0;
        v_finish = 1'b0;
        v_low    = '0;

        v_ph    = (r_phase > PH_READ) ? PH_IDLE : r_phase;
        v_tick  = r_tick;
        v_bit   = r_bit;
        v_shift = r_shift;

        if (v_ph == PH_IDLE) begin
            if (i_cmd.start_reset) begin
                v_ph   = PH_RLOW;
                v_tick = '0;
            end else if (i_cmd.start_write) begin
                v_ph    = PH_WRITE;
                v_shift = i_cmd.tx_byte;
                v_bit   = '0;
                v_tick  = '0;
            end else if (i_cmd.start_read) begin
                v_ph    = PH_READ;
                v_shift = '0;
                v_bit   = '0;
                v_tick  = '0;
            end
        end

        v_inc   = v_tick + CNT_ONE;
        n_phase = v_ph;
        n_tick  = v_tick;
        n_bit   = v_bit;
        n_shift = v_shift;

        case (v_ph)
            PH_RLOW: begin
                v_drive = 1'b1;
                n_tick  = v_inc;
                if (v_inc >= r_eff[owbm_pkg::REG_RESET_LOW]) begin
                    n_phase = PH_RREL;
                    n_tick  = '0;
                end
            end
            PH_RREL: begin
                n_tick = v_inc;
                if (v_inc >= r_eff[owbm_pkg::REG_PRES_SAMPLE]) begin
                    n_tick = '0;
                    if (!i_cmd.bus_level) begin
                        n_pres  = 1'b1;
                        n_phase = PH_RHIGH;
                    end else begin
                        n_pres  = 1'b0;
                        n_phase = PH_IDLE;
                        v_done  = 1'b1;
                    end
                end
            end
            PH_RHIGH: begin
                if (i_cmd.bus_level) begin
                    n_phase = PH_IDLE;
                    v_done  = 1'b1;
                end
            end
            PH_WRITE: begin
                v_low   = v_shift[0] ? r_eff[owbm_pkg::REG_WR1_LOW] :
                                       r_eff[owbm_pkg::REG_WR0_LOW];
                v_drive = (v_tick < v_low);
                n_tick  = v_inc;
                if (v_inc >= r_eff[owbm_pkg::REG_WR_SLOT]) begin
                    n_shift  = {1'b0, v_shift[7:1]};
                    v_finish = 1'b1;
                end
            end
            PH_READ: begin
                v_drive = (v_tick < r_eff[owbm_pkg::REG_RD_LOW]);
                if (v_tick == v_sp) begin
                    n_shift = {i_cmd.bus_level, v_shift[7:1]};
                end
                n_tick = v_inc;
                if (v_inc >= r_eff[owbm_pkg::REG_RD_SLOT]) begin
                    if (v_bit == 3'd7) begin
                        n_rx = n_shift;
                    end
                    v_finish = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // end of a write or read slot
        if (v_finish) begin
            n_tick = '0;
            if (v_bit == 3'd7) begin
                n_bit   = '0;
                n_phase = PH_IDLE;
                v_done  = 1'b1;
            end else begin
                n_bit = v_bit + 1'b1;
            end
        end

        n_out.bus_drive_low = v_drive;
        n_out.busy_res      = (n_phase != PH_IDLE);
        n_out.done_res      = v_done;
        n_out.presence      = n_pres;
        n_out.rx_byte       = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_pres      <= 1'b0;
            r_rx        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_pres  <= n_pres;
                r_rx    <= n_rx;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

### design/one_wire_bus_master.sv
// One-wire bus master, one tick request per microsecond.
// A tick request goes through the queue register, then the output register, to m_tdata.
// Throughput: one tick request per cycle unless a result stalls in the output register.
// Reset: i_rst_n synchronous, active low; clears queue, engine and output valid,
//   and loads the timing registers with their default values.
module one_wire_bus_master #(
    parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // [7:0] tx_byte, [8] bus_level, rest 0
    input  logic [1:0]                       s_tuser,  // [1:0] op
    // results, one per tick
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,  // [0] bus_drive_low, [1] busy_res,
                                                       // [2] done_res, [3] presence,
                                                       // [11:4] rx_byte, rest 0
    // timing register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    owbm_pkg::t_cmd       w_front_cmd;
    owbm_pkg::t_cmd       w_head_cmd;
    owbm_pkg::t_fifo_stat w_fifo_stat;
    owbm_pkg::t_res       w_res;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_cfg_we;

    // registers are always writable; writes are to come only while the bus is idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // front: decode opcode into start flags
    owbm_front u_front (
        .i_op        (s_tuser),
        .i_tx_byte   (s_tdata[7:0]),
        .i_bus_level (s_tdata[8]),
        .o_cmd       (w_front_cmd)
    );

    // short queue lets the input keep streaming while a result waits downstream
    assign s_tready = !w_fifo_stat.full;
    assign w_push   = s_tvalid && s_tready;

    owbm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .i_pop   (w_pop),
        .o_data  (w_head_cmd),
        .o_stat  (w_fifo_stat)
    );

    // back: reset / write / read slot engine plus output register
    owbm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (!w_fifo_stat.empty),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_res_valid (m_tvalid),
        .i_res_ready (m_tready),
        .o_res       (w_res)
    );

    assign m_tdata = {4'd0, w_res.rx_byte, w_res.presence, w_res.done_res,
                      w_res.busy_res, w_res.bus_drive_low};

    // engine must not advance while a result is stuck in the output register
    a_no_pop_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |-> !w_pop)
        else $error("engine advanced over a stalled result");

    // a finished command never reports itself still busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(w_res.done_res && w_res.busy_res))
        else $error("done and busy on the same tick");

    // queue occupancy stays within its depth
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_stat.count <= owbm_pkg::FIFO_CNT_W'(owbm_pkg::FIFO_DEPTH))
        else $error("command queue overflow");

    // a request taken into an empty queue is seen at its head on the next edge
    a_push_reaches_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_fifo_stat.empty && !w_pop) |=> !w_fifo_stat.empty)
        else $error("pushed request lost");

endmodule

### test/tb_one_wire_bus_master.sv
module tb_one_wire_bus_master;
    import owbm_pkg::*;

    localparam int NPLAN          = 21;
    localparam int RAND_PHASES    = 7;
    localparam int PHASE_TICKS    = 30;
    localparam int END_WAIT       = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    // slot engine phases of the predictor
    typedef enum logic [2:0] {
        PH_IDLE, PH_RLOW, PH_RREL, PH_RHIGH, PH_WRITE, PH_READ
    } wire_phase_e;

    typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] timing_set_t;

    typedef enum logic [1:0] {ROW_TICK, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {SET_MIN, SET_SKEW, SET_MAX} set_id_e;

    // one line of the directed plan; reps 0 runs the command until the engine is idle
    typedef struct packed {
        row_kind_e  kind;
        set_id_e    set_id;
        logic [1:0] op;
        logic [7:0] tx;
        logic       bus;
        logic [4:0] reps;
        logic       typed;
        t_res       want;
    } plan_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [7:0] tx_byte, [8] bus_level, rest 0
    logic [1:0]  s_tuser = OP_TICK; // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] drive, [1] busy, [2] done, [3] presence, [11:4] rx
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = REG_RESET_LOW;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    one_wire_bus_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    wire_phase_e wire_ph;
    logic [9:0]  slot_tc;
    logic [2:0]  bit_idx;
    logic [7:0]  shift_q;
    logic        pres_q;
    logic [7:0]  rx_q;
    timing_set_t timing_q;

    t_res expected_res [$];
    int   err_count = 0;
    int   quiet_cycles = 0;
    int   stall_left = 0;
    bit   calm = 1'b0;           // no idling on either side while set
    bit   glance_pending = 1'b0; // current request carries a hand-written result
    t_res glance_res = '0;

    plan_row_t plan [NPLAN];

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // register below its floor behaves as the floor
    function automatic logic [9:0] eff_ticks(input logic [CFG_INDEX_W-1:0] idx);
        return (timing_q[idx] < REG_MIN_VAL[idx]) ? REG_MIN_VAL[idx] : timing_q[idx];
    endfunction

    task automatic end_of_slot(inout logic done);
        slot_tc = '0;
        if (bit_idx == 3'd7) begin
            bit_idx = '0;
            wire_ph = PH_IDLE;
            done    = 1'b1;
        end else begin
            bit_idx = bit_idx + 3'd1;
        end
    endtask

    // one tick of the bus master: commands only start from idle
    task automatic wire_step(input logic [1:0] op, input logic [7:0] tx, input logic bus,
                             output t_res r);
        logic       drive;
        logic       done;
        logic [9:0] slot;
        logic [9:0] sample_at;
        drive = 1'b0;
        done  = 1'b0;
        if (wire_ph == PH_IDLE) begin
            case (op)
                OP_RESET: begin
                    wire_ph = PH_RLOW;
                    slot_tc = '0;
                end
                OP_WRITE: begin
                    wire_ph = PH_WRITE;
                    shift_q = tx;
                    bit_idx = '0;
                    slot_tc = '0;
                end
                OP_READ: begin
                    wire_ph = PH_READ;
                    shift_q = '0;
                    bit_idx = '0;
                    slot_tc = '0;
                end
                default: ;
            endcase
        end
        case (wire_ph)
            PH_RLOW: begin
                drive   = 1'b1;
                slot_tc = slot_tc + 10'd1;
                if (slot_tc >= eff_ticks(REG_RESET_LOW)) begin
                    wire_ph = PH_RREL;
                    slot_tc = '0;
                end
            end
            PH_RREL: begin
                slot_tc = slot_tc + 10'd1;
                if (slot_tc >= eff_ticks(REG_PRES_SAMPLE)) begin
                    slot_tc = '0;
                    pres_q  = !bus;
                    if (!bus) begin
                        wire_ph = PH_RHIGH;
                    end else begin
                        wire_ph = PH_IDLE;
                        done    = 1'b1;
                    end
                end
            end
            // slave still holding the line: no time limit
            PH_RHIGH: begin
                if (bus) begin
                    wire_ph = PH_IDLE;
                    done    = 1'b1;
                end
            end
            PH_WRITE: begin
                drive   = slot_tc < (shift_q[0] ? eff_ticks(REG_WR1_LOW) : eff_ticks(REG_WR0_LOW));
                slot_tc = slot_tc + 10'd1;
                if (slot_tc >= eff_ticks(REG_WR_SLOT)) begin
                    shift_q = shift_q >> 1;
                    end_of_slot(done);
                end
            end
            PH_READ: begin
                slot      = eff_ticks(REG_RD_SLOT);
                // sample point past the slot end falls back to the last tick
                sample_at = (eff_ticks(REG_RD_SAMPLE) < slot) ? eff_ticks(REG_RD_SAMPLE)
                                                              : slot - 10'd1;
                drive     = slot_tc < eff_ticks(REG_RD_LOW);
                if (slot_tc == sample_at) shift_q = {bus, shift_q[7:1]};
                slot_tc = slot_tc + 10'd1;
                if (slot_tc >= slot) begin
                    if (bit_idx == 3'd7) rx_q = shift_q;
                    end_of_slot(done);
                end
            end
            default: ;
        endcase
        r.bus_drive_low = drive;
        r.busy_res      = (wire_ph != PH_IDLE);
        r.done_res      = done;
        r.presence      = pres_q;
        r.rx_byte       = rx_q;
    endtask

    function automatic t_res status_word(input logic drive, input logic busy, input logic done,
                                         input logic pres, input logic [7:0] rx);
        t_res r;
        r.bus_drive_low = drive;
        r.busy_res      = busy;
        r.done_res      = done;
        r.presence      = pres;
        r.rx_byte       = rx;
        return r;
    endfunction

    function automatic plan_row_t tick_row(input logic [1:0] op, input logic [7:0] tx,
                                           input logic bus, input logic [4:0] reps);
        plan_row_t row;
        row        = '0;
        row.kind   = ROW_TICK;
        row.op     = op;
        row.tx     = tx;
        row.bus    = bus;
        row.reps   = reps;
        return row;
    endfunction

    function automatic plan_row_t typed_row(input logic [1:0] op, input logic [7:0] tx,
                                            input logic bus, input t_res want);
        plan_row_t row;
        row       = tick_row(op, tx, bus, 5'd1);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input set_id_e set_id);
        plan_row_t row;
        row        = '0;
        row.kind   = ROW_CFG;
        row.set_id = set_id;
        return row;
    endfunction

    function automatic timing_set_t timing_of(input set_id_e set_id);
        timing_set_t s;
        case (set_id)
            SET_MAX: s = '1;
            // write lows beyond the slot, read sample and read low beyond the read slot
            SET_SKEW: begin
                s[REG_RESET_LOW]   = 10'd3;
                s[REG_PRES_SAMPLE] = 10'd2;
                s[REG_WR1_LOW]     = 10'd10;
                s[REG_WR0_LOW]     = 10'd20;
                s[REG_WR_SLOT]     = 10'd8;
                s[REG_RD_LOW]      = 10'd6;
                s[REG_RD_SAMPLE]   = 10'd9;
                s[REG_RD_SLOT]     = 10'd5;
            end
            default: s = '0; // every register under its floor
        endcase
        return s;
    endfunction

    // mostly short timings, now and then a longer one; zero hits the floors
    function automatic timing_set_t random_timing();
        timing_set_t s;
        for (int i = 0; i < NUM_REGS; i++)
            s[i] = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(11, 40))
                                               : 10'($urandom_range(0, 6));
        return s;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_tick(input logic [1:0] op, input logic [7:0] tx, input logic bus,
                             input logic typed, input t_res want);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid       <= 1'b1;
        s_tdata        <= {7'd0, bus, tx};
        s_tuser        <= op;
        glance_pending = typed;
        glance_res     = want;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_res.size() != 0);
    endtask

    // nothing in flight when called
    task automatic write_timing(input timing_set_t s);
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_INDEX_W'(i);
            i_cfg_data  <= s[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            timing_q[i] = s[i];
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // tick requests continue, with random content, until the command has finished
    task automatic run_to_idle();
        while (wire_ph != PH_IDLE)
            send_tick(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // receiver back-pressure: short stalls mostly, a few long ones
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(7, 29)
                                                      : $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // prediction on accepted requests, comparison on accepted results
    always @(posedge i_clk) begin
        t_res pred;
        t_res got;
        t_res want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                wire_step(s_tuser, s_tdata[7:0], s_tdata[8], pred);
                expected_res.push_back(glance_pending ? glance_res : pred);
            end
            if (m_tvalid && m_tready) begin
                got = t_res'(m_tdata[11:0]);
                if (expected_res.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request outstanding", got));
                end else begin
                    want = expected_res.pop_front();
                    if (got.bus_drive_low !== want.bus_drive_low)
                        report_mismatch($sformatf("bus_drive_low got %b want %b",
                                                  got.bus_drive_low, want.bus_drive_low));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res got %b want %b",
                                                  got.busy_res, want.busy_res));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res got %b want %b",
                                                  got.done_res, want.done_res));
                    if (got.presence !== want.presence)
                        report_mismatch($sformatf("presence got %b want %b",
                                                  got.presence, want.presence));
                    if (got.rx_byte !== want.rx_byte)
                        report_mismatch($sformatf("rx_byte got %h want %h",
                                                  got.rx_byte, want.rx_byte));
                end
            end
        end
    end

    // ends the run if no handshake completes for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [1:0] op;
        int         pick;

        wire_ph  = PH_IDLE;
        slot_tc  = '0;
        bit_idx  = '0;
        shift_q  = '0;
        pres_q   = 1'b0;
        rx_q     = '0;
        for (int i = 0; i < NUM_REGS; i++) timing_q[i] = REG_RESET_VAL[i];

        plan = '{
            // straight after reset: idle, nothing driven, nothing latched
            typed_row(OP_TICK,  8'h00, 1'b1, '0),
            typed_row(OP_TICK,  8'hFF, 1'b0, '0),
            cfg_row(SET_MIN),
            // first tick of a reset pulls the line low
            typed_row(OP_RESET, 8'h00, 1'b0, status_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00)),
            tick_row(OP_TICK,  8'h00, 1'b0, 5'd1),  // presence seen
            tick_row(OP_WRITE, 8'h3C, 1'b0, 5'd3),  // line held low, command ignored
            tick_row(OP_TICK,  8'h00, 1'b1, 5'd1),
            tick_row(OP_WRITE, 8'hA5, 1'b1, 5'd16),
            tick_row(OP_READ,  8'hFF, 1'b1, 5'd24),
            tick_row(OP_READ,  8'h00, 1'b0, 5'd24),
            tick_row(OP_RESET, 8'h00, 1'b1, 5'd2),  // no presence pulse
            tick_row(OP_TICK,  8'hFF, 1'b1, 5'd1),
            cfg_row(SET_SKEW),
            tick_row(OP_WRITE, 8'h00, 1'b1, 5'd0),
            tick_row(OP_WRITE, 8'hFF, 1'b1, 5'd0),
            tick_row(OP_READ,  8'h5A, 1'b1, 5'd0),
            tick_row(OP_RESET, 8'h00, 1'b0, 5'd0),
            // full-scale slot held low, then cut short when the timings drop to the floors
            cfg_row(SET_MAX),
            tick_row(OP_WRITE, 8'h6B, 1'b1, 5'd24),
            cfg_row(SET_MIN),
            tick_row(OP_TICK,  8'h00, 1'b1, 5'd0)
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed plan
        for (int k = 0; k < NPLAN; k++) begin
            if (plan[k].kind == ROW_CFG) begin
                wait_drain();
                write_timing(timing_of(plan[k].set_id));
            end else begin
                send_tick(plan[k].op, plan[k].tx, plan[k].bus, plan[k].typed, plan[k].want);
                if (plan[k].reps == 0)
                    run_to_idle();
                else
                    repeat (plan[k].reps - 1)
                        send_tick(OP_TICK, plan[k].tx, plan[k].bus, 1'b0, '0);
            end
        end

        // random phases, each with its own timing set; one phase without idling
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drain();
            write_timing(random_timing());
            calm = (p == 3);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (p == 1 && n == PHASE_TICKS / 2) wait_drain();
                if (wire_ph == PH_IDLE) begin
                    pick = $urandom_range(0, 9);
                    op   = (pick < 1) ? OP_TICK : (pick < 4) ? OP_RESET
                         : (pick < 7) ? OP_WRITE : OP_READ;
                end else begin
                    op = 2'($urandom_range(0, 3));
                end
                send_tick(op, 8'($urandom), 1'($urandom), 1'b0, '0);
            end
            run_to_idle();
        end
        calm = 1'b0;

        wait_drain();
        repeat (END_WAIT) @(negedge i_clk);
        if (expected_res.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_res.size()));
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
design/owbm_pkg.sv
design/owbm_front.sv
design/owbm_fifo.sv
design/owbm_back.sv
design/one_wire_bus_master.sv
test/tb_one_wire_bus_master.sv
